// ----- src/cpam_pkg.sv -----
// ---------------------------------------------------------------------------
// cpam_pkg
// Shared constants, register indexes and saturation helpers for the cascaded
// PI attitude controller with X-quad motor mixer.
// ---------------------------------------------------------------------------
package cpam_pkg;

    // field and port widths
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned THR_W   = 8;
    localparam int unsigned MOTOR_W = 8;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned INTEG_W = 32;

    // default motor ceiling
    localparam int unsigned MOTOR_MAX_DEFAULT = 255;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_ANGLE_KP     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ANGLE_KI     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_RATE_KP      = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RATE_KI      = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ROLL_TARGET  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_PITCH_TARGET = 3'd5;
    localparam logic [ADDR_W-1:0] REG_YAW_TARGET   = 3'd6;

    // gain reset values, Q8.8
    localparam logic [DATA_W-1:0] GAIN_ONE  = 16'd256;
    localparam logic [DATA_W-1:0] GAIN_ZERO = 16'd0;

    // axis indexes
    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    typedef logic signed [36:0] wide_t;

    // saturate to the signed 16-bit range
    function automatic logic signed [15:0] sat_s16(input wide_t x);
        logic signed [15:0] res;
        if (x > 37'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (x < -37'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = x[15:0];
        end
        return res;
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input wide_t x);
        logic signed [31:0] res;
        if (x > 37'sd2147483647)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (x < -37'sd2147483648)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ----- src/cascaded_pi_attitude_motor_mix_top.sv -----
// ---------------------------------------------------------------------------
// cascaded_pi_attitude_motor_mix_top
// Cascaded PI attitude loops for roll, pitch and yaw on one shared multiplier,
// followed by an X-quad mixer with clamped motor outputs.
// ---------------------------------------------------------------------------
// A new tick is accepted only while the sequencer is idle, so beats do not overlap;
//   each axis takes 8 sequencer steps, six of them multiplies on the single 34x17
//   multiplier, plus a mixer and an idle step.
// A finished beat waits in the output register while the next tick is accepted.
// Reset (async, active low): gains to 1.0 / 0, targets and integrals to zero,
//   sequencer idle, no output beat pending.
module cascaded_pi_attitude_motor_mix_top #(
    parameter int unsigned MOTOR_MAX = cpam_pkg::MOTOR_MAX_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [cpam_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [cpam_pkg::DATA_W-1:0]          cfg_wdata,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cpam_pkg::DATA_W-1:0]   roll_angle,
    input  logic signed [cpam_pkg::DATA_W-1:0]   roll_rate,
    input  logic signed [cpam_pkg::DATA_W-1:0]   pitch_angle,
    input  logic signed [cpam_pkg::DATA_W-1:0]   pitch_rate,
    input  logic signed [cpam_pkg::DATA_W-1:0]   yaw_angle,
    input  logic signed [cpam_pkg::DATA_W-1:0]   yaw_rate,
    input  logic [cpam_pkg::THR_W-1:0]           throttle_level,
    input  logic [cpam_pkg::DATA_W-1:0]          time_step,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cpam_pkg::MOTOR_W-1:0]         motor_a,
    output logic [cpam_pkg::MOTOR_W-1:0]         motor_b,
    output logic [cpam_pkg::MOTOR_W-1:0]         motor_c,
    output logic [cpam_pkg::MOTOR_W-1:0]         motor_d,
    output logic signed [cpam_pkg::DATA_W-1:0]   roll_drive,
    output logic signed [cpam_pkg::DATA_W-1:0]   pitch_drive,
    output logic signed [cpam_pkg::DATA_W-1:0]   yaw_drive
);
    import cpam_pkg::*;

    // sequencer steps
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_AKP  = 4'd1;
    localparam logic [3:0] ST_AKI  = 4'd2;
    localparam logic [3:0] ST_ADT  = 4'd3;
    localparam logic [3:0] ST_RKP  = 4'd4;
    localparam logic [3:0] ST_RKI  = 4'd5;
    localparam logic [3:0] ST_RDT  = 4'd6;
    localparam logic [3:0] ST_RINT = 4'd7;
    localparam logic [3:0] ST_DRV  = 4'd8;
    localparam logic [3:0] ST_MIX  = 4'd9;

    localparam logic [16:0] MotorMaxW = 17'(MOTOR_MAX);

    // control state
    logic [3:0]                state_reg, state_next;
    logic [1:0]                axis_reg, axis_next;
    logic                      out_valid_reg, out_valid_next;

    // configuration registers
    logic [DATA_W-1:0]         angle_kp_reg, angle_ki_reg, rate_kp_reg, rate_ki_reg;
    logic signed [DATA_W-1:0]  target_reg [3];

    // integrator state
    logic signed [INTEG_W-1:0] ang_int_reg [3];
    logic signed [INTEG_W-1:0] ang_int_next [3];
    logic signed [INTEG_W-1:0] rate_int_reg [3];
    logic signed [INTEG_W-1:0] rate_int_next [3];

    // held input beat
    logic signed [DATA_W-1:0]  angle_in_reg [3];
    logic signed [DATA_W-1:0]  rate_in_reg [3];
    logic [THR_W-1:0]          thr_reg;
    logic [DATA_W-1:0]         dt_reg;

    // datapath registers
    logic signed [50:0]        prod_reg;
    logic signed [15:0]        desired_reg, desired_next;
    logic signed [16:0]        r_reg, r_next;
    logic signed [24:0]        p_reg, p_next;
    logic signed [15:0]        drive_reg [3];
    logic signed [15:0]        drive_next [3];
    logic [MOTOR_W-1:0]        motor_a_reg, motor_b_reg, motor_c_reg, motor_d_reg;
    logic signed [15:0]        roll_out_reg, pitch_out_reg, yaw_out_reg;

    // shared multiplier
    logic signed [33:0]        mul_a;
    logic signed [16:0]        mul_b;
    logic signed [50:0]        mul_p;

    // per-axis operands
    logic signed [15:0]        tgt_sel, ang_sel, rate_sel;
    logic signed [16:0]        e_w;
    logic signed [35:0]        inc_w;
    logic signed [36:0]        integ_sum;
    logic signed [36:0]        drive_sum;
    logic                      load_out;

    // mixer
    logic                      thr_off;
    logic signed [18:0]        thr_q7;
    logic signed [18:0]        roll_x, pitch_x, yaw_x;
    logic signed [18:0]        sum_a, sum_b, sum_c, sum_d;

    function automatic logic [MOTOR_W-1:0] mix_motor(input logic signed [18:0] s,
                                                     input logic off);
        logic [MOTOR_W-1:0] res;
        logic [16:0]        m;
        m = {5'b0, s[18:7]};
        if (off || s[18])
        begin
            res = '0;
        end
        else if (m > MotorMaxW)
        begin
            res = MotorMaxW[MOTOR_W-1:0];
        end
        else
        begin
            res = m[MOTOR_W-1:0];
        end
        return res;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_MIX) && (!out_valid_reg || out_ready);

    // axis operand selection
    assign tgt_sel  = target_reg[axis_reg];
    assign ang_sel  = angle_in_reg[axis_reg];
    assign rate_sel = rate_in_reg[axis_reg];
    assign e_w      = $signed({tgt_sel[15], tgt_sel}) - $signed({ang_sel[15], ang_sel});

    // multiplier operand mux
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_AKP:
            begin
                mul_a = $signed({18'b0, angle_kp_reg});
                mul_b = e_w;
            end
            ST_AKI:
            begin
                mul_a = $signed({18'b0, angle_ki_reg});
                mul_b = e_w;
            end
            ST_ADT, ST_RDT:
            begin
                mul_a = prod_reg[33:0];
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_RKP:
            begin
                mul_a = $signed({18'b0, rate_kp_reg});
                mul_b = r_reg;
            end
            ST_RKI:
            begin
                mul_a = $signed({18'b0, rate_ki_reg});
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // integral increment and accumulate, shared by both integrators
    assign inc_w = prod_reg[50:15];
    always_comb
    begin
        if (state_reg == ST_RINT)
        begin
            integ_sum = $signed({{5{rate_int_reg[axis_reg][31]}}, rate_int_reg[axis_reg]})
                      + $signed({inc_w[35], inc_w});
        end
        else
        begin
            integ_sum = $signed({{5{ang_int_reg[axis_reg][31]}}, ang_int_reg[axis_reg]})
                      + $signed({inc_w[35], inc_w});
        end
    end

    // axis drive sum
    assign drive_sum = $signed({{12{p_reg[24]}}, p_reg})
                     + $signed({{14{rate_int_reg[axis_reg][31]}}, rate_int_reg[axis_reg][31:9]})
                     + $signed({{14{ang_int_reg[axis_reg][31]}}, ang_int_reg[axis_reg][31:9]});

    // X mixer sums in Q12.7
    assign thr_off = (thr_reg == '0);
    assign thr_q7  = $signed({4'b0, thr_reg, 7'b0});
    assign roll_x  = $signed({{3{drive_reg[AXIS_ROLL][15]}}, drive_reg[AXIS_ROLL]});
    assign pitch_x = $signed({{3{drive_reg[AXIS_PITCH][15]}}, drive_reg[AXIS_PITCH]});
    assign yaw_x   = $signed({{3{drive_reg[AXIS_YAW][15]}}, drive_reg[AXIS_YAW]});
    assign sum_a   = thr_q7 + yaw_x + roll_x + pitch_x;
    assign sum_b   = thr_q7 + yaw_x - roll_x + pitch_x;
    assign sum_c   = thr_q7 + yaw_x - roll_x - pitch_x;
    assign sum_d   = thr_q7 - yaw_x + roll_x - pitch_x;

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        desired_next   = desired_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        ang_int_next   = ang_int_reg;
        rate_int_next  = rate_int_reg;
        drive_next     = drive_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_AKP;
                    axis_next  = AXIS_ROLL;
                end
            end
            ST_AKP:
            begin
                state_next = ST_AKI;
            end
            ST_AKI:
            begin
                desired_next = sat_s16($signed({{12{prod_reg[32]}}, prod_reg[32:8]}));
                state_next   = ST_ADT;
            end
            ST_ADT:
            begin
                r_next     = $signed({desired_reg[15], desired_reg})
                           - $signed({rate_sel[15], rate_sel});
                state_next = ST_RKP;
            end
            ST_RKP:
            begin
                ang_int_next[axis_reg] = sat_s32(integ_sum);
                state_next             = ST_RKI;
            end
            ST_RKI:
            begin
                p_next     = prod_reg[32:8];
                state_next = ST_RDT;
            end
            ST_RDT:
            begin
                state_next = ST_RINT;
            end
            ST_RINT:
            begin
                rate_int_next[axis_reg] = sat_s32(integ_sum);
                state_next              = ST_DRV;
            end
            ST_DRV:
            begin
                drive_next[axis_reg] = sat_s16(drive_sum);
                if (axis_reg == AXIS_YAW)
                begin
                    state_next = ST_MIX;
                    axis_next  = AXIS_ROLL;
                end
                else
                begin
                    state_next = ST_AKP;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            ST_MIX:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                axis_next  = AXIS_ROLL;
            end
        endcase
    end

    // control, configuration and integrator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_ROLL;
            out_valid_reg <= 1'b0;
            angle_kp_reg  <= GAIN_ONE;
            angle_ki_reg  <= GAIN_ZERO;
            rate_kp_reg   <= GAIN_ONE;
            rate_ki_reg   <= GAIN_ZERO;
            for (int i = 0; i < 3; i++)
            begin
                target_reg[i]   <= '0;
                ang_int_reg[i]  <= '0;
                rate_int_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            ang_int_reg   <= ang_int_next;
            rate_int_reg  <= rate_int_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ANGLE_KP:     angle_kp_reg <= cfg_wdata;
                    REG_ANGLE_KI:     angle_ki_reg <= cfg_wdata;
                    REG_RATE_KP:      rate_kp_reg  <= cfg_wdata;
                    REG_RATE_KI:      rate_ki_reg  <= cfg_wdata;
                    REG_ROLL_TARGET:  target_reg[AXIS_ROLL]  <= cfg_wdata;
                    REG_PITCH_TARGET: target_reg[AXIS_PITCH] <= cfg_wdata;
                    REG_YAW_TARGET:   target_reg[AXIS_YAW]   <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_p;
        desired_reg <= desired_next;
        r_reg       <= r_next;
        p_reg       <= p_next;
        drive_reg   <= drive_next;
        if (in_valid && in_ready)
        begin
            angle_in_reg[AXIS_ROLL]  <= roll_angle;
            angle_in_reg[AXIS_PITCH] <= pitch_angle;
            angle_in_reg[AXIS_YAW]   <= yaw_angle;
            rate_in_reg[AXIS_ROLL]   <= roll_rate;
            rate_in_reg[AXIS_PITCH]  <= pitch_rate;
            rate_in_reg[AXIS_YAW]    <= yaw_rate;
            thr_reg                  <= throttle_level;
            dt_reg                   <= time_step;
        end
        if (load_out)
        begin
            motor_a_reg   <= mix_motor(sum_a, thr_off);
            motor_b_reg   <= mix_motor(sum_b, thr_off);
            motor_c_reg   <= mix_motor(sum_c, thr_off);
            motor_d_reg   <= mix_motor(sum_d, thr_off);
            roll_out_reg  <= drive_reg[AXIS_ROLL];
            pitch_out_reg <= drive_reg[AXIS_PITCH];
            yaw_out_reg   <= drive_reg[AXIS_YAW];
        end
    end

    // output ports
    assign out_valid   = out_valid_reg;
    assign motor_a     = motor_a_reg;
    assign motor_b     = motor_b_reg;
    assign motor_c     = motor_c_reg;
    assign motor_d     = motor_d_reg;
    assign roll_drive  = roll_out_reg;
    assign pitch_drive = pitch_out_reg;
    assign yaw_drive   = yaw_out_reg;

`ifndef SYNTHESIS
    // an accepted beat starts the roll axis multiply chain
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_AKP && axis_reg == AXIS_ROLL))
        else $error("accepted beat did not start the sequencer");

    // the yaw drive step always hands over to the mixer
    a_yaw_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRV && axis_reg == AXIS_YAW) |=> (state_reg == ST_MIX))
        else $error("sequencer skipped the mixer step");

    // the axis counter is parked on roll whenever the sequencer is idle
    a_idle_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (axis_reg == AXIS_ROLL))
        else $error("axis counter not parked while idle");

    // zero throttle gives zero on all motors
    a_thr_off: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && thr_off) |=>
            (out_valid && motor_a == '0 && motor_b == '0 && motor_c == '0 && motor_d == '0))
        else $error("motor output nonzero at zero throttle");
`endif

endmodule

// ----- tb/cascaded_pi_attitude_motor_mix_top_test.sv -----
// ---------------------------------------------------------------------------
// cascaded_pi_attitude_motor_mix_top_test
// Drives control ticks into the cascaded PI attitude controller and compares
// every motor mix beat with a cycle-free model of the three axis loops, the
// integrators and the X-quad mixer, under random idling and a long output stall.
// ---------------------------------------------------------------------------
module cascaded_pi_attitude_motor_mix_top_test;

    import cpam_pkg::*;

    localparam int     CLK_PERIOD   = 20;
    localparam int     RESET_CYCLES = 11;
    localparam int     IDLE_PAD     = 40;
    localparam longint LIMIT_CYCLES = 2_000_000;
    localparam int     TICKS_PER_PHASE = 83;
    localparam int     PRESSURE_TICKS  = 16;
    localparam int     CHK_W           = DATA_W + 1;

    localparam longint MOTOR_LIMIT = MOTOR_MAX_DEFAULT;
    localparam longint Q97_LO      = -32768;
    localparam longint Q97_HI      = 32767;
    localparam longint INTEG_LO    = -(64'sd1 <<< 31);
    localparam longint INTEG_HI    = (64'sd1 <<< 31) - 1;

    localparam logic signed [DATA_W-1:0] Q97_MAX  = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q97_MIN  = 16'sh8000;
    localparam logic signed [DATA_W-1:0] Q97_ZERO = 16'sh0000;
    localparam logic [DATA_W-1:0]        GAIN_MAX = 16'hFFFF;
    localparam logic [DATA_W-1:0]        GAIN_128 = 16'h8000;
    localparam logic [DATA_W-1:0]        DT_MAX   = 16'hFFFF;
    localparam logic [DATA_W-1:0]        DT_HALF  = 16'h8000;
    localparam logic [ADDR_W-1:0]        REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] roll_angle, roll_rate;
        logic signed [DATA_W-1:0] pitch_angle, pitch_rate;
        logic signed [DATA_W-1:0] yaw_angle, yaw_rate;
        logic [THR_W-1:0]         throttle_level;
        logic [DATA_W-1:0]        time_step;
    } tick_t;

    typedef struct {
        logic [MOTOR_W-1:0]       motor_a, motor_b, motor_c, motor_d;
        logic signed [DATA_W-1:0] roll_drive, pitch_drive, yaw_drive;
    } mix_t;

    // clock, reset and block ports
    logic clk;
    logic rst_n = 1'b0;

    logic              cfg_we    = 1'b0;
    logic [ADDR_W-1:0] cfg_addr  = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    logic                     in_valid       = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] roll_angle     = '0;
    logic signed [DATA_W-1:0] roll_rate      = '0;
    logic signed [DATA_W-1:0] pitch_angle    = '0;
    logic signed [DATA_W-1:0] pitch_rate     = '0;
    logic signed [DATA_W-1:0] yaw_angle      = '0;
    logic signed [DATA_W-1:0] yaw_rate       = '0;
    logic [THR_W-1:0]         throttle_level = '0;
    logic [DATA_W-1:0]        time_step      = '0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [MOTOR_W-1:0]       motor_a, motor_b, motor_c, motor_d;
    logic signed [DATA_W-1:0] roll_drive, pitch_drive, yaw_drive;

    // controller mirror: gains, set points and integrators
    logic [DATA_W-1:0]         gain_angle_kp, gain_angle_ki, gain_rate_kp, gain_rate_ki;
    logic signed [DATA_W-1:0]  set_point [3];
    logic signed [INTEG_W-1:0] angle_integ [3];
    logic signed [INTEG_W-1:0] rate_integ [3];

    mix_t pending_mix [$];

    int send_idle_pct  = 37;
    int recv_idle_pct  = 76;
    int rx_hold_cycles = 0;
    int ticks_sent     = 0;
    int mixes_checked  = 0;
    int config_loads   = 0;
    int err_count      = 0;

    cascaded_pi_attitude_motor_mix_top #(
        .MOTOR_MAX(MOTOR_MAX_DEFAULT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .roll_angle    (roll_angle),
        .roll_rate     (roll_rate),
        .pitch_angle   (pitch_angle),
        .pitch_rate    (pitch_rate),
        .yaw_angle     (yaw_angle),
        .yaw_rate      (yaw_rate),
        .throttle_level(throttle_level),
        .time_step     (time_step),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .motor_a       (motor_a),
        .motor_b       (motor_b),
        .motor_c       (motor_c),
        .motor_d       (motor_d),
        .roll_drive    (roll_drive),
        .pitch_drive   (pitch_drive),
        .yaw_drive     (yaw_drive)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2);
            clk = ~clk;
        end
    end

    // fixed-point helpers
    function automatic longint sat_range(input longint x, input longint lo, input longint hi);
        if (x < lo)
        begin
            return lo;
        end
        if (x > hi)
        begin
            return hi;
        end
        return x;
    endfunction

    // one axis: outer angle P plus integrator, inner rate PI; updates the integrators
    function automatic longint step_axis(input logic [1:0] axis, input longint angle,
                                         input longint rate, input longint dt);
        longint err, desired, inc, rate_err, drive;
        err     = longint'(set_point[axis]) - angle;
        desired = sat_range((longint'(gain_angle_kp) * err) >>> 8, Q97_LO, Q97_HI);
        inc     = (longint'(gain_angle_ki) * err * dt) >>> 15;
        angle_integ[axis] = INTEG_W'(sat_range(longint'(angle_integ[axis]) + inc,
                                               INTEG_LO, INTEG_HI));
        rate_err = desired - rate;
        inc      = (longint'(gain_rate_ki) * rate_err * dt) >>> 15;
        rate_integ[axis] = INTEG_W'(sat_range(longint'(rate_integ[axis]) + inc,
                                              INTEG_LO, INTEG_HI));
        drive = ((longint'(gain_rate_kp) * rate_err) >>> 8)
              + (longint'(rate_integ[axis]) >>> 9)
              + (longint'(angle_integ[axis]) >>> 9);
        return sat_range(drive, Q97_LO, Q97_HI);
    endfunction

    // one motor: zero when throttle is off or the mix is negative, else clamped
    function automatic logic [MOTOR_W-1:0] mix_motor(input bit off, input longint sum);
        longint m;
        if (off || sum < 0)
        begin
            return '0;
        end
        m = sum >>> 7;
        if (m > MOTOR_LIMIT)
        begin
            m = MOTOR_LIMIT;
        end
        return m[MOTOR_W-1:0];
    endfunction

    function automatic mix_t predict_motor_mix(input tick_t t);
        mix_t   res;
        longint roll, pitch, yaw, base;
        bit     off;
        roll  = step_axis(AXIS_ROLL, longint'(t.roll_angle), longint'(t.roll_rate),
                          longint'(t.time_step));
        pitch = step_axis(AXIS_PITCH, longint'(t.pitch_angle), longint'(t.pitch_rate),
                          longint'(t.time_step));
        yaw   = step_axis(AXIS_YAW, longint'(t.yaw_angle), longint'(t.yaw_rate),
                          longint'(t.time_step));
        base  = longint'(t.throttle_level) * 128;
        off   = (t.throttle_level == 0);
        res.motor_a     = mix_motor(off, base + yaw + roll + pitch);
        res.motor_b     = mix_motor(off, base + yaw - roll + pitch);
        res.motor_c     = mix_motor(off, base + yaw - roll - pitch);
        res.motor_d     = mix_motor(off, base - yaw + roll - pitch);
        res.roll_drive  = roll[DATA_W-1:0];
        res.pitch_drive = pitch[DATA_W-1:0];
        res.yaw_drive   = yaw[DATA_W-1:0];
        return res;
    endfunction

    // configuration writes, mirrored into the model at the same time
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ANGLE_KP:     gain_angle_kp = val;
            REG_ANGLE_KI:     gain_angle_ki = val;
            REG_RATE_KP:      gain_rate_kp  = val;
            REG_RATE_KI:      gain_rate_ki  = val;
            REG_ROLL_TARGET:  set_point[AXIS_ROLL]  = val;
            REG_PITCH_TARGET: set_point[AXIS_PITCH] = val;
            REG_YAW_TARGET:   set_point[AXIS_YAW]   = val;
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
        config_loads++;
    endtask

    task automatic load_config(input logic [DATA_W-1:0] akp, input logic [DATA_W-1:0] aki,
                               input logic [DATA_W-1:0] rkp, input logic [DATA_W-1:0] rki,
                               input logic signed [DATA_W-1:0] roll_sp,
                               input logic signed [DATA_W-1:0] pitch_sp,
                               input logic signed [DATA_W-1:0] yaw_sp);
        write_reg(REG_ANGLE_KP, akp);
        write_reg(REG_ANGLE_KI, aki);
        write_reg(REG_RATE_KP, rkp);
        write_reg(REG_RATE_KI, rki);
        write_reg(REG_ROLL_TARGET, roll_sp);
        write_reg(REG_PITCH_TARGET, pitch_sp);
        write_reg(REG_YAW_TARGET, yaw_sp);
        end_writes();
    endtask

    // input beat: optional random gap, then hold valid until accepted
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        roll_angle     <= t.roll_angle;
        roll_rate      <= t.roll_rate;
        pitch_angle    <= t.pitch_angle;
        pitch_rate     <= t.pitch_rate;
        yaw_angle      <= t.yaw_angle;
        yaw_rate       <= t.yaw_rate;
        throttle_level <= t.throttle_level;
        time_step      <= t.time_step;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_mix.push_back(predict_motor_mix(t));
        ticks_sent++;
    endtask

    task automatic send_vals(input logic signed [DATA_W-1:0] ra, input logic signed [DATA_W-1:0] rr,
                             input logic signed [DATA_W-1:0] pa, input logic signed [DATA_W-1:0] pr,
                             input logic signed [DATA_W-1:0] ya, input logic signed [DATA_W-1:0] yr,
                             input logic [THR_W-1:0] thr, input logic [DATA_W-1:0] dt);
        tick_t t;
        t.roll_angle     = ra;
        t.roll_rate      = rr;
        t.pitch_angle    = pa;
        t.pitch_rate     = pr;
        t.yaw_angle      = ya;
        t.yaw_rate       = yr;
        t.throttle_level = thr;
        t.time_step      = dt;
        send_tick(t);
    endtask

    // stop offering, let every outstanding beat come back, then settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // random stimulus: mostly near the set point, sometimes anywhere or at a rail
    function automatic logic signed [DATA_W-1:0] rand_q97(input logic signed [DATA_W-1:0] centre);
        int v;
        case ($urandom_range(7))
            0:       v = $urandom;
            1:       v = int'($urandom_range(1) ? Q97_MAX : Q97_MIN);
            default: v = centre + int'($urandom_range(2048)) - 1024;
        endcase
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain(input int unsigned cap);
        case ($urandom_range(9))
            0:       return GAIN_ZERO;
            1:       return GAIN_MAX;
            2:       return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(cap));
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.roll_angle  = rand_q97(set_point[AXIS_ROLL]);
        t.roll_rate   = rand_q97(Q97_ZERO);
        t.pitch_angle = rand_q97(set_point[AXIS_PITCH]);
        t.pitch_rate  = rand_q97(Q97_ZERO);
        t.yaw_angle   = rand_q97(set_point[AXIS_YAW]);
        t.yaw_rate    = rand_q97(Q97_ZERO);
        case ($urandom_range(9))
            0:       t.throttle_level = '0;
            1:       t.throttle_level = '1;
            2:       t.throttle_level = THR_W'($urandom);
            default: t.throttle_level = THR_W'($urandom_range(200, 40));
        endcase
        case ($urandom_range(9))
            0:       t.time_step = '0;
            1:       t.time_step = DATA_W'($urandom);
            default: t.time_step = DATA_W'($urandom_range(2000, 1));
        endcase
        return t;
    endfunction

    // result check
    task automatic check_field(input string name, input logic signed [DATA_W:0] want,
                               input logic signed [DATA_W:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_mix_beat();
        mix_t want;
        if (pending_mix.size() == 0)
        begin
            $error("output beat with no control tick outstanding");
            err_count++;
        end
        else
        begin
            want = pending_mix.pop_front();
            check_field("motor_a", CHK_W'(want.motor_a), CHK_W'(motor_a));
            check_field("motor_b", CHK_W'(want.motor_b), CHK_W'(motor_b));
            check_field("motor_c", CHK_W'(want.motor_c), CHK_W'(motor_c));
            check_field("motor_d", CHK_W'(want.motor_d), CHK_W'(motor_d));
            check_field("roll_drive", CHK_W'(want.roll_drive), CHK_W'(roll_drive));
            check_field("pitch_drive", CHK_W'(want.pitch_drive), CHK_W'(pitch_drive));
            check_field("yaw_drive", CHK_W'(want.yaw_drive), CHK_W'(yaw_drive));
            mixes_checked++;
        end
    endtask

    // output side: check each accepted beat, then pick the next ready level
    initial
    begin : mix_receiver
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_mix_beat();
            end
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // reset defaults, zero throttle and a bare hover
    task automatic test_reset_defaults();
        send_vals(Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, 8'd0, 16'd0);
        send_vals(Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, 8'd255, 16'd100);
        send_vals(16'sd256, -16'sd128, -16'sd384, 16'sd64, 16'sd128, Q97_ZERO, 8'd0, 16'd500);
        send_vals(16'sd64, Q97_ZERO, -16'sd64, Q97_ZERO, 16'sd32, Q97_ZERO, 8'd1, 16'd1);
        wait_idle();
    endtask

    // field rails: desired rate, drive and motor clamps in both directions
    task automatic test_field_extremes();
        send_vals(Q97_MIN, Q97_MAX, Q97_MAX, Q97_MIN, Q97_MIN, Q97_MIN, 8'd128, DT_MAX);
        send_vals(Q97_MAX, Q97_MIN, Q97_MIN, Q97_MAX, Q97_MAX, Q97_MAX, 8'd255, DT_MAX);
        send_vals(Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, 8'd0, 16'd0);
        send_vals(-16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 8'd255, 16'd1);
        wait_idle();
    endtask

    // full-scale P gains with set points at the rails
    task automatic test_gain_saturation();
        load_config(GAIN_MAX, GAIN_ZERO, GAIN_MAX, GAIN_ZERO, Q97_MAX, Q97_MIN, Q97_MAX);
        send_vals(Q97_MIN, Q97_ZERO, Q97_MAX, Q97_ZERO, Q97_ZERO, Q97_ZERO, 8'd200, 16'd1000);
        send_vals(Q97_MAX, Q97_MIN, Q97_MIN, Q97_MAX, Q97_MAX, Q97_ZERO, 8'd50, 16'd0);
        send_vals(16'sd32000, Q97_ZERO, -16'sd32000, Q97_ZERO, 16'sd32760, Q97_ZERO,
                  8'd128, 16'd0);
        wait_idle();
    endtask

    // writes to the unused index must not land anywhere
    task automatic test_register_map();
        write_reg(REG_UNUSED, GAIN_MAX);
        write_reg(REG_ANGLE_KP, 16'd128);
        write_reg(REG_RATE_KP, 16'd384);
        write_reg(REG_ROLL_TARGET, 16'd640);
        write_reg(REG_PITCH_TARGET, -16'sd640);
        write_reg(REG_YAW_TARGET, 16'd1280);
        write_reg(REG_UNUSED, GAIN_ZERO);
        end_writes();
        send_vals(16'sd512, 16'sd100, -16'sd512, -16'sd100, 16'sd1000, 16'sd50, 8'd100, 16'd300);
        send_vals(Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, Q97_ZERO, 8'd100, 16'd300);
        wait_idle();
    endtask

    // integrators: saturate low, hold on zero step, saturate high and low again,
    // then unwind exactly back to zero with two half-scale steps
    task automatic test_integral_limits();
        load_config(GAIN_ZERO, GAIN_MAX, GAIN_ZERO, GAIN_MAX, Q97_ZERO, Q97_ZERO, Q97_ZERO);
        send_vals(Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, 8'd100, DT_MAX);
        send_vals(Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, 8'd100, 16'd0);
        send_vals(Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, 8'd100, DT_MAX);
        send_vals(Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, 8'd100, DT_MAX);
        send_vals(Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, Q97_MAX, 8'd100, DT_MAX);
        wait_idle();
        load_config(GAIN_ZERO, GAIN_128, GAIN_ZERO, GAIN_128, Q97_ZERO, Q97_ZERO, Q97_ZERO);
        send_vals(Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, 8'd100, DT_HALF);
        send_vals(Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, Q97_MIN, 8'd100, DT_HALF);
        wait_idle();
    endtask

    // long output stall while ticks keep coming, so the input side backs up
    task automatic test_backpressure();
        set_idling(0, 0);
        load_config(16'd256, 16'd16, 16'd256, 16'd16, Q97_ZERO, Q97_ZERO, Q97_ZERO);
        rx_hold_cycles = 400;
        for (int i = 0; i < PRESSURE_TICKS; i++)
        begin
            send_tick(random_tick());
        end
        wait_idle();
    endtask

    // random flight: three idling modes, three gain and set-point loads each
    task automatic test_random_flight();
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       set_idling(37, 76);
                1:       set_idling(76, 37);
                default: set_idling(0, 0);
            endcase
            for (int phase = 0; phase < 3; phase++)
            begin
                load_config(rand_gain(768), rand_gain(64), rand_gain(768), rand_gain(64),
                            rand_q97(Q97_ZERO), rand_q97(Q97_ZERO), rand_q97(Q97_ZERO));
                for (int n = 0; n < TICKS_PER_PHASE; n++)
                begin
                    send_tick(random_tick());
                end
                wait_idle();
            end
        end
    endtask

    // test sequence
    initial
    begin : stimulus
        gain_angle_kp = GAIN_ONE;
        gain_angle_ki = GAIN_ZERO;
        gain_rate_kp  = GAIN_ONE;
        gain_rate_ki  = GAIN_ZERO;
        for (int a = 0; a < 3; a++)
        begin
            set_point[a]   = '0;
            angle_integ[a] = '0;
            rate_integ[a]  = '0;
        end
        set_idling(37, 76);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_gain_saturation();
        test_register_map();
        test_integral_limits();
        test_backpressure();
        test_random_flight();
        wait_idle();

        if (pending_mix.size() != 0)
        begin
            $error("%0d expected motor mix beats never arrived", pending_mix.size());
            err_count++;
        end
        $display("Covered %0d control ticks over %0d gain/set-point loads: rails, zero throttle,",
                 ticks_sent, config_loads);
        $display("integrator wind-up and unwind, output stall; %0d mix beats compared.",
                 mixes_checked);
        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin : run_limit
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
